>>> rtl/core/sha256_pkg.sv
// Shared types, constants and round functions for the SHA-256 message hasher.
package sha256_pkg;

  typedef logic [7:0][31:0] word8_t;
  typedef logic [15:0][31:0] word16_t;

  // Controls from the sequencer to the round datapath
  typedef struct packed {
    logic       init;   // load working variables from the chaining words
    logic       load;   // shift an assembled message word into the schedule
    logic       step;   // run one compression round
    logic       sched;  // round 16 or later: expand the schedule
    logic [5:0] idx;    // round number
  } rnd_ctl_t;

  localparam word8_t HashInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;
  localparam logic [5:0] LastPos = 6'd63;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/core/sha256_message_hasher_top.sv
// Top level of the byte-serial SHA-256 message hasher: sequencer, padding and digest output.
//
//  channel | direction | fields                                   | handshake
//  --------+-----------+------------------------------------------+--------------------------
//  in      | to core   | data_byte_i, byte_present_i, message_end_i | in_valid_i / in_stall_o
//  out     | from core | digest_word_o, word_number_o, digest_done_o | out_valid_o / out_stall_i
//
// The core takes one message byte per cycle while in_stall_o is low. Every 64th byte starts a
// compression (64 rounds in the shared round unit, then one fold), during which input stalls.
// The final transaction writes the padding bytes, switches to the length bytes, compresses
// each padded block (two blocks when the length spills), then emits eight outputs.
// Reset loads the initial hash and clears the byte count; no clearing pass is needed.
// in_stall_o is high while the sequencer is busy; out_stall_i holds the output register.
module sha256_message_hasher_top import sha256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        message_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_number_o,
  output logic        digest_done_o
);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FOLD  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  // Padding phases
  localparam logic [1:0] PH_MARK = 2'd0;
  localparam logic [1:0] PH_ZERO = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;
  localparam logic [1:0] PH_FIN  = 2'd3;

  logic [2:0]  state_q, state_d;
  logic [1:0]  ph_q, ph_d;
  logic        pad_q, pad_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [5:0]  pos_q;
  logic [63:0] count_q;
  logic [23:0] word_q;
  word8_t      chain_q;
  word8_t      vars;
  logic [2:0]  onum_q;
  logic        out_valid_q;
  logic [31:0] out_word_q;
  logic [2:0]  out_num_q;
  logic        out_done_q;

  logic        byte_wr;
  logic [7:0]  byte_val;
  logic        cnt_inc;
  logic        fold;
  logic        out_load;
  logic        digest_last;
  rnd_ctl_t    rctl;
  logic [63:0] len_bits;
  logic [63:0] len_sh;

  // Big-endian bit length; byte k of the trailer is bits 63-8k down to 56-8k
  assign len_bits = {count_q[60:0], 3'b000};
  assign len_sh   = len_bits >> {~pos_q[2:0], 3'b000};
  assign digest_last = (onum_q == 3'd7);

  always_comb begin
    state_d  = state_q;
    ph_d     = ph_q;
    pad_d    = pad_q;
    rnd_d    = rnd_q;
    byte_wr  = 1'b0;
    byte_val = data_byte_i;
    cnt_inc  = 1'b0;
    fold     = 1'b0;
    out_load = 1'b0;
    rctl     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (byte_present_i) begin
            byte_wr = 1'b1;
            cnt_inc = 1'b1;
          end
          // Close the message: pad after any pending compression
          if (message_end_i) begin
            pad_d   = 1'b1;
            ph_d    = PH_MARK;
            state_d = S_PAD;
          end
          if (byte_present_i && pos_q == LastPos) begin
            state_d = S_ROUND;
          end
        end
      end
      S_PAD: begin
        unique case (ph_q)
          PH_MARK: begin
            byte_wr  = 1'b1;
            byte_val = PadMark;
            ph_d     = PH_ZERO;
          end
          PH_ZERO: begin
            if (pos_q == LenPos) begin
              ph_d = PH_LEN;
            end else begin
              byte_wr  = 1'b1;
              byte_val = 8'h00;
            end
          end
          PH_LEN: begin
            byte_wr  = 1'b1;
            byte_val = len_sh[7:0];
            if (pos_q == LastPos) begin
              ph_d = PH_FIN;
            end
          end
          default: begin
            ph_d = PH_FIN;
          end
        endcase
        if (byte_wr && pos_q == LastPos) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        rctl.step  = 1'b1;
        rctl.idx   = rnd_q;
        rctl.sched = (rnd_q[5:4] != 2'b00);
        rnd_d      = rnd_q + 6'd1;
        if (rnd_q == LastPos) begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        fold = 1'b1;
        if (!pad_q) begin
          state_d = S_IDLE;
        end else if (ph_q == PH_FIN) begin
          state_d = S_OUT;
        end else begin
          state_d = S_PAD;
        end
      end
      S_OUT: begin
        // Advance when the output register is free or being drained
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          if (digest_last) begin
            pad_d   = 1'b0;
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Every fourth byte completes a word; the last byte of a block starts compression
    rctl.load = byte_wr && (pos_q[1:0] == 2'b11);
    rctl.init = byte_wr && (pos_q == LastPos);
  end

  sha256_round u_round (
    .clk_i  (clk_i),
    .ctl_i  (rctl),
    .word_i ({word_q, byte_val}),
    .chain_i(chain_q),
    .vars_o (vars)
  );

  // Control and chaining state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_q        <= PH_MARK;
      pad_q       <= 1'b0;
      rnd_q       <= '0;
      pos_q       <= '0;
      count_q     <= '0;
      chain_q     <= HashInit;
      onum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      pad_q   <= pad_d;
      rnd_q   <= rnd_d;
      if (byte_wr) begin
        pos_q <= pos_q + 6'd1;
      end
      if (cnt_inc) begin
        count_q <= count_q + 64'd1;
      end else if (out_load && digest_last) begin
        count_q <= '0;
      end
      if (fold) begin
        for (int j = 0; j < 8; j++) begin
          chain_q[j] <= chain_q[j] + vars[j];
        end
      end else if (out_load && digest_last) begin
        chain_q <= HashInit;
      end
      if (out_load) begin
        onum_q <= onum_q + 3'd1;
      end
      // Hold the word while stalled, drop it once taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (byte_wr) begin
      word_q <= {word_q[15:0], byte_val};
    end
    if (out_load) begin
      out_word_q <= chain_q[onum_q];
      out_num_q  <= onum_q;
      out_done_q <= digest_last;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign digest_word_o = out_word_q;
  assign word_number_o = out_num_q;
  assign digest_done_o = out_done_q;

`ifndef SYNTHESIS
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("output transaction raised outside the output phase");

  a_rnd_in_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rnd_q != 6'd0 |-> state_q == S_ROUND)
    else $error("round counter left non-zero between blocks");

  a_out_needs_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |-> pad_q && ph_q == PH_FIN)
    else $error("digest output without completed padding");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && digest_last |=> state_q == S_IDLE && count_q == 64'd0)
    else $error("core not returned to initial state after digest");
`endif

endmodule

>>> rtl/core/sha256_round.sv
// Shared compression round unit with working variables and rolling message schedule.
module sha256_round import sha256_pkg::*; (
  input  logic        clk_i,
  input  rnd_ctl_t    ctl_i,
  input  logic [31:0] word_i,
  input  word8_t      chain_i,
  output word8_t      vars_o
);

  word8_t      vars_q;
  word16_t     win_q;
  logic [31:0] w;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  // Oldest schedule word sits at index 0
  always_comb begin
    if (ctl_i.sched) begin
      w = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
    end else begin
      w = win_q[0];
    end
    ch  = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
    maj = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
    t1  = vars_q[7] + big_sigma1(vars_q[4]) + ch + round_k(ctl_i.idx) + w;
    t2  = big_sigma0(vars_q[0]) + maj;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.init) begin
      vars_q <= chain_i;
    end else if (ctl_i.step) begin
      vars_q <= {vars_q[6], vars_q[5], vars_q[4], vars_q[3] + t1,
                 vars_q[2], vars_q[1], vars_q[0], t1 + t2};
    end
    if (ctl_i.load) begin
      win_q <= {word_i, win_q[15:1]};
    end else if (ctl_i.step) begin
      win_q <= {w, win_q[15:1]};
    end
  end

  assign vars_o = vars_q;

endmodule
